// ===== hw/rtl/blpsr_pkg.sv =====
`default_nettype none
package blpsr_pkg;

  localparam int unsigned CAPACITY = 16;
  localparam int unsigned IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CNT_W    = $clog2(CAPACITY + 1);

  localparam int unsigned FUNC_W   = 2;
  localparam int unsigned VALUE_W  = 32;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned COUNT_W  = 5;

  typedef logic [IDX_W-1:0] idx_t;
  typedef logic [CNT_W-1:0] cnt_t;

  typedef enum logic [FUNC_W-1:0] {
    FN_PUSH   = 2'd0,
    FN_POP    = 2'd1,
    FN_SEARCH = 2'd2,
    FN_REMOVE = 2'd3
  } func_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK   = 2'd0,
    ST_MISS = 2'd1,
    ST_FULL = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_WALK,
    S_RESP
  } state_e;

  // controller to datapath
  typedef struct packed {
    logic start;
    logic step;
    logic finish;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic walk_done;
  } stat_t;

  // ring index add, both operands below CAPACITY
  function automatic idx_t ring_add(idx_t a, idx_t b);
    logic [IDX_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= (IDX_W+1)'(CAPACITY)) begin
      s = s - (IDX_W+1)'(CAPACITY);
    end
    return s[IDX_W-1:0];
  endfunction

  function automatic idx_t ring_dec(idx_t a);
    idx_t r;
    if (a == '0) begin
      r = IDX_W'(CAPACITY - 1);
    end else begin
      r = a - idx_t'(1);
    end
    return r;
  endfunction

  // low bits of the count for the result field
  function automatic logic [COUNT_W-1:0] count_field(cnt_t c);
    logic [31:0] t;
    t = 32'(c);
    return t[COUNT_W-1:0];
  endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/blpsr_if.sv =====
`default_nettype none
interface blpsr_req_if
  import blpsr_pkg::*;
();
  logic                       valid;
  logic                       ready;
  logic [FUNC_W-1:0]          func;
  logic signed [VALUE_W-1:0]  value;

  modport source (output valid, output func, output value, input ready);
  modport sink   (input valid, input func, input value, output ready);
endinterface

interface blpsr_rsp_if
  import blpsr_pkg::*;
();
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [COUNT_W-1:0]  count;

  modport source (output valid, output status, output count, input ready);
  modport sink   (input valid, input status, input count, output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/blpsr_ctrl.sv =====
`default_nettype none
module blpsr_ctrl
  import blpsr_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              req_valid_i,
  input  wire logic [FUNC_W-1:0] req_func_i,
  output logic                   req_ready_o,
  output logic                   rsp_valid_o,
  input  wire logic              rsp_ready_i,
  input  wire stat_t             stat_i,
  output cmd_t                   cmd_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    req_ready_o = 1'b0;
    rsp_valid_o = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        req_ready_o = 1'b1;
        if (req_valid_i) begin
          cmd_o.start = 1'b1;
          // push and pop finish at once, search and remove walk the list
          if (func_e'(req_func_i) == FN_PUSH || func_e'(req_func_i) == FN_POP) begin
            state_d = S_RESP;
          end else begin
            state_d = S_WALK;
          end
        end
      end
      S_WALK: begin
        cmd_o.step = 1'b1;
        if (stat_i.walk_done) begin
          cmd_o.finish = 1'b1;
          state_d      = S_RESP;
        end
      end
      S_RESP: begin
        rsp_valid_o = 1'b1;
        if (rsp_ready_i) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

endmodule
`default_nettype wire

// ===== hw/rtl/blpsr_dp.sv =====
`default_nettype none
module blpsr_dp
  import blpsr_pkg::*;
(
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire cmd_t                      cmd_i,
  input  wire logic [FUNC_W-1:0]         func_i,
  input  wire logic signed [VALUE_W-1:0] value_i,
  output stat_t                          stat_o,
  output logic [STATUS_W-1:0]            status_o,
  output logic [COUNT_W-1:0]             count_o
);

  logic [VALUE_W-1:0] mem [CAPACITY];

  idx_t               head_q, head_d;
  cnt_t               count_q, count_d;
  cnt_t               rd_idx_q, rd_idx_d;
  cnt_t               kept_q, kept_d;
  logic               cmp_vld_q, cmp_vld_d;
  logic               found_q, found_d;
  status_e            status_q, status_d;
  func_e              func_q;
  logic [VALUE_W-1:0] value_q;
  logic [VALUE_W-1:0] rd_data_q;

  logic               issue;
  logic               match;
  idx_t               rd_addr;
  logic               we;
  idx_t               waddr;
  logic [VALUE_W-1:0] wdata;

  assign issue   = cmd_i.step && (rd_idx_q < count_q);
  assign match   = cmp_vld_q && (rd_data_q == value_q);
  assign rd_addr = ring_add(head_q, rd_idx_q[IDX_W-1:0]);

  assign stat_o.walk_done = (rd_idx_q >= count_q) && !cmp_vld_q;

  always_comb begin
    head_d    = head_q;
    count_d   = count_q;
    rd_idx_d  = rd_idx_q;
    kept_d    = kept_q;
    cmp_vld_d = 1'b0;
    found_d   = found_q;
    status_d  = status_q;
    we        = 1'b0;
    waddr     = ring_dec(head_q);
    wdata     = VALUE_W'(value_i);

    if (cmd_i.start) begin
      rd_idx_d = '0;
      kept_d   = '0;
      found_d  = 1'b0;
      status_d = ST_OK;
      unique case (func_e'(func_i))
        FN_PUSH: begin
          if (count_q == CNT_W'(CAPACITY)) begin
            status_d = ST_FULL;
          end else begin
            we      = 1'b1;
            head_d  = ring_dec(head_q);
            count_d = count_q + cnt_t'(1);
          end
        end
        FN_POP: begin
          if (count_q == '0) begin
            status_d = ST_MISS;
          end else begin
            head_d  = ring_add(head_q, idx_t'(1));
            count_d = count_q - cnt_t'(1);
          end
        end
        FN_SEARCH, FN_REMOVE: ;
        default: ;
      endcase
    end else if (cmd_i.step) begin
      if (issue) begin
        rd_idx_d = rd_idx_q + cnt_t'(1);
      end
      cmp_vld_d = issue;
      if (match) begin
        found_d = 1'b1;
      end
      // compact survivors toward the front; write slot never passes the read slot
      if (cmp_vld_q && !match && func_q == FN_REMOVE) begin
        we     = 1'b1;
        waddr  = ring_add(head_q, kept_q[IDX_W-1:0]);
        wdata  = rd_data_q;
        kept_d = kept_q + cnt_t'(1);
      end
      if (cmd_i.finish) begin
        status_d = found_q ? ST_OK : ST_MISS;
        if (func_q == FN_REMOVE) begin
          count_d = kept_q;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q    <= '0;
      count_q   <= '0;
      rd_idx_q  <= '0;
      kept_q    <= '0;
      cmp_vld_q <= 1'b0;
      found_q   <= 1'b0;
      status_q  <= ST_OK;
    end else begin
      head_q    <= head_d;
      count_q   <= count_d;
      rd_idx_q  <= rd_idx_d;
      kept_q    <= kept_d;
      cmp_vld_q <= cmp_vld_d;
      found_q   <= found_d;
      status_q  <= status_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      func_q  <= func_e'(func_i);
      value_q <= VALUE_W'(value_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rd_data_q <= mem[rd_addr];
  end

  assign status_o = status_q;
  assign count_o  = count_field(count_q);

endmodule
`default_nettype wire

// ===== hw/rtl/bounded_list_push_search_remove.sv =====
// Ordered list of up to CAPACITY signed 32-bit values kept as a ring in a
// single-port-write, single-port-read memory. Each request item carries one
// operation (push front, pop front, search, remove all matches) and yields
// one result item with a status and the count afterwards. One item is in
// flight at a time: push and pop offer the result right after acceptance,
// while search and remove first walk the stored entries, one memory read
// per cycle. After the result is taken, the next request is accepted in
// the following cycle.
`default_nettype none
module bounded_list_push_search_remove
  import blpsr_pkg::*;
(
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  blpsr_req_if.sink   req_i,
  blpsr_rsp_if.source rsp_o
);

  cmd_t  cmd;
  stat_t stat;

  blpsr_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_i.valid),
    .req_func_i  (req_i.func),
    .req_ready_o (req_i.ready),
    .rsp_valid_o (rsp_o.valid),
    .rsp_ready_i (rsp_o.ready),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  blpsr_dp u_dp (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cmd_i    (cmd),
    .func_i   (req_i.func),
    .value_i  (req_i.value),
    .stat_o   (stat),
    .status_o (rsp_o.status),
    .count_o  (rsp_o.count)
  );

endmodule
`default_nettype wire

// ===== hw/rtl/blpsr_checker.sv =====
`default_nettype none
module blpsr_checker
  import blpsr_pkg::*;
(
  input wire logic                clk_i,
  input wire logic                rst_ni,
  input wire logic                req_valid_i,
  input wire logic                req_ready_i,
  input wire logic                rsp_valid_i,
  input wire logic                rsp_ready_i,
  input wire logic [STATUS_W-1:0] rsp_status_i,
  input wire logic [COUNT_W-1:0]  rsp_count_i
);

  // one item at a time: no new item while a result is offered
  a_no_accept_during_rsp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i |-> !req_ready_i)
    else $error("request ready while result pending");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_valid_i && req_ready_i) |=> !req_ready_i)
    else $error("second item accepted right after the first");

  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i |-> (rsp_status_i == ST_OK || rsp_status_i == ST_MISS ||
                     rsp_status_i == ST_FULL))
    else $error("bad status code");

  // full is only reported with a full list
  a_full_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_valid_i && rsp_status_i == ST_FULL) |-> (rsp_count_i == COUNT_W'(CAPACITY)))
    else $error("full reported with list not full");

  a_rsp_once: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_valid_i && rsp_ready_i) |=> !rsp_valid_i)
    else $error("result repeated");

endmodule

bind bounded_list_push_search_remove blpsr_checker u_blpsr_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .req_valid_i  (req_i.valid),
  .req_ready_i  (req_i.ready),
  .rsp_valid_i  (rsp_o.valid),
  .rsp_ready_i  (rsp_o.ready),
  .rsp_status_i (rsp_o.status),
  .rsp_count_i  (rsp_o.count)
);
`default_nettype wire
